FILE: hdl/u8cp_pkg.sv
// shared types and constants of the utf-8 to code point decoder
package u8cp_pkg;

  localparam int unsigned BufDepth = 4;
  localparam int unsigned CntW     = 3;

  localparam logic [20:0] Replacement = 21'h00FFFD;
  localparam logic [20:0] MaxCodePt   = 21'h10FFFF;
  localparam logic [20:0] SurrLo      = 21'h00D800;
  localparam logic [20:0] SurrHi      = 21'h00DFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        rejected;
    logic        last_result;
  } out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic discarding;
    logic stop;
    logic final_step;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/u8cp_datapath.sv
// byte buffer, sequence decode and result register of the decoder
module u8cp_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  u8cp_pkg::cmd_t   cmd_i,
  output u8cp_pkg::sts_t   sts_o,
  input  u8cp_pkg::in_t    in_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output u8cp_pkg::out_t   out_data_o
);

  logic [7:0]                buf_q [u8cp_pkg::BufDepth];
  logic [u8cp_pkg::CntW-1:0] cnt_q;
  logic                      eos_q;
  logic                      discarding_q;
  logic                      strict_q;
  logic                      out_valid_q;
  u8cp_pkg::out_t            out_q;

  logic [7:0]                b0;
  logic [1:0]                need;
  logic                      bad_lead;
  logic                      cont_bad;
  logic                      range_bad;
  logic                      incomplete;
  logic                      is_err;
  logic [20:0]               cp;
  logic [u8cp_pkg::CntW-1:0] consume;
  logic [u8cp_pkg::CntW-1:0] cnt_after;
  logic                      strict_err;

  always_comb begin
    b0       = buf_q[0];
    need     = 2'd0;
    bad_lead = 1'b0;
    cp       = 21'd0;
    unique case (b0) inside
      8'b0???????: begin
        cp = {13'd0, b0};
      end
      8'b110?????: begin
        need = 2'd1;
        cp   = {10'd0, b0[4:0], buf_q[1][5:0]};
      end
      8'b1110????: begin
        need = 2'd2;
        cp   = {5'd0, b0[3:0], buf_q[1][5:0], buf_q[2][5:0]};
      end
      8'b11110???: begin
        need = 2'd3;
        cp   = {b0[2:0], buf_q[1][5:0], buf_q[2][5:0], buf_q[3][5:0]};
      end
      default: begin
        bad_lead = 1'b1;
      end
    endcase

    // sequence not yet complete within the buffered bytes
    incomplete = !bad_lead && ({1'b0, need} >= cnt_q);

    cont_bad = 1'b0;
    if (need >= 2'd1 && buf_q[1][7:6] != 2'b10) cont_bad = 1'b1;
    if (need >= 2'd2 && buf_q[2][7:6] != 2'b10) cont_bad = 1'b1;
    if (need == 2'd3 && buf_q[3][7:6] != 2'b10) cont_bad = 1'b1;

    range_bad = (cp > u8cp_pkg::MaxCodePt) ||
                (cp >= u8cp_pkg::SurrLo && cp <= u8cp_pkg::SurrHi);

    is_err = bad_lead || incomplete || cont_bad || range_bad;

    if (bad_lead || (!incomplete && (cont_bad || range_bad))) begin
      consume = u8cp_pkg::CntW'(1);
    end else if (incomplete) begin
      consume = cnt_q;
    end else begin
      consume = u8cp_pkg::CntW'(need) + u8cp_pkg::CntW'(1);
    end
    cnt_after  = cnt_q - consume;
    strict_err = is_err && strict_q;
  end

  assign sts_o.discarding = discarding_q;
  assign sts_o.stop       = incomplete && !eos_q;
  assign sts_o.final_step = strict_err || (cnt_after == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      eos_q        <= 1'b0;
      discarding_q <= 1'b0;
      strict_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        strict_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        if (discarding_q) begin
          if (in_data_i.end_of_string) discarding_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + u8cp_pkg::CntW'(1);
          eos_q <= in_data_i.end_of_string;
        end
      end
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
        if (strict_err) begin
          cnt_q        <= '0;
          discarding_q <= !eos_q;
        end else begin
          cnt_q <= cnt_after;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !discarding_q) begin
      buf_q[cnt_q[1:0]] <= in_data_i.data_byte;
    end
    if (cmd_i.step) begin
      if (strict_err) begin
        out_q <= '{code_point: '0, rejected: 1'b1, last_result: 1'b1};
      end else begin
        out_q.code_point  <= is_err ? u8cp_pkg::Replacement : cp;
        out_q.rejected    <= 1'b0;
        out_q.last_result <= eos_q && (cnt_after == '0);
      end
      // drop consumed bytes from the front
      case (consume)
        3'd1: begin
          buf_q[0] <= buf_q[1];
          buf_q[1] <= buf_q[2];
          buf_q[2] <= buf_q[3];
        end
        3'd2: begin
          buf_q[0] <= buf_q[2];
          buf_q[1] <= buf_q[3];
        end
        3'd3: begin
          buf_q[0] <= buf_q[3];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/u8cp_ctrl.sv
// control state machine of the decoder
module u8cp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  u8cp_pkg::sts_t sts_i,
  output u8cp_pkg::cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q;
  logic   in_ready_q;

  always_comb begin
    cmd_o.load = in_valid_i && in_ready_q;
    cmd_o.step = (state_q == StRun) && !sts_i.stop && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      in_ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (cmd_o.load && !sts_i.discarding) begin
            state_q    <= StRun;
            in_ready_q <= 1'b0;
          end
        end
        StRun: begin
          if (sts_i.stop || (cmd_o.step && sts_i.final_step)) begin
            state_q    <= StIdle;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= StIdle;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

FILE: hdl/utf8_to_codepoint_decoder_top.sv
// top level of the utf-8 to code point decoder
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_ready_o | data_byte, end_of_string
//  out     | output    | out_valid_o/out_ready_i| code_point, rejected, last_result
//  cfg     | input     | cfg_valid_i/cfg_ready_o| strict_mode
//
// an item is accepted in the idle state and then decoded in the run state, one result per
// step while the result register is free, up to 4 results per byte; a byte that only
// extends a pending sequence still passes through the run state
// reset clears the byte count, the discard flag, the mode and the result valid flag
// while the result register is full and not taken the step waits and the input stays closed
// the next item is taken while the final result of the previous one is still on the output
module utf8_to_codepoint_decoder_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  u8cp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output u8cp_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i
);

  u8cp_pkg::cmd_t cmd;
  u8cp_pkg::sts_t sts;

  // mode writes are to arrive only while idle; the block does not enforce this and always takes them
  assign cfg_ready_o = 1'b1;

  // sequencing of load and decode steps
  u8cp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // held bytes, one sequence decode per step and the result register
  u8cp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: bench/utf8_to_codepoint_decoder_top_tb.sv
// self-checking testbench of the utf-8 to code point decoder top level
module utf8_to_codepoint_decoder_top_tb;

  // tracks the decoder state, predicts the code points of each item and checks results
  class codepoint_tracker;
    logic [7:0]     held_bytes[3];
    int unsigned    held_cnt;
    bit             skipping;
    bit             strict;
    u8cp_pkg::out_t expected_cps[$];
    int unsigned    errors;
    int unsigned    decoded_bytes;

    function new();
      held_cnt      = 0;
      skipping      = 1'b0;
      strict        = 1'b0;
      errors        = 0;
      decoded_bytes = 0;
    endfunction

    function void set_mode(bit mode);
      strict = mode;
    endfunction

    function void queue_result(u8cp_pkg::out_t res);
      expected_cps = {expected_cps, res};
    endfunction

    // returns 1 when the byte is decoded, 0 when a rejected string swallows it
    function bit predict_byte(u8cp_pkg::in_t item);
      logic [7:0]     seq[4];
      logic [7:0]     lead;
      logic [7:0]     cont;
      logic [20:0]    cp;
      int unsigned    n;
      int unsigned    pos;
      int unsigned    need;
      int unsigned    cnt;
      bit             bad;
      bit             incomplete;
      bit             eos;
      u8cp_pkg::out_t res;
      eos = item.end_of_string;
      if (skipping) begin
        if (eos) skipping = 1'b0;
        return 1'b0;
      end
      decoded_bytes++;
      n = held_cnt;
      for (int i = 0; i < 3; i++) begin
        if (i < n) seq[i] = held_bytes[i];
      end
      seq[n] = item.data_byte;
      n++;
      pos = 0;
      cnt = 0;
      while (pos < n) begin
        lead       = seq[pos];
        need       = 0;
        cp         = '0;
        bad        = 1'b0;
        incomplete = 1'b0;
        if (lead < 8'h80) begin
          cp = {13'd0, lead};
        end else if ((lead & 8'hE0) == 8'hC0) begin
          need = 1;
          cp   = {16'd0, lead[4:0]};
        end else if ((lead & 8'hF0) == 8'hE0) begin
          need = 2;
          cp   = {17'd0, lead[3:0]};
        end else if ((lead & 8'hF8) == 8'hF0) begin
          need = 3;
          cp   = {18'd0, lead[2:0]};
        end else begin
          bad = 1'b1;
        end
        // sequence still open: hold it unless the string ends here
        if (!bad && pos + need >= n) begin
          if (!eos) break;
          incomplete = 1'b1;
        end
        if (!bad && !incomplete) begin
          for (int k = 1; k <= need; k++) begin
            cont = seq[pos+k];
            if ((cont & 8'hC0) != 8'h80) begin
              bad = 1'b1;
              break;
            end
            cp = {cp[14:0], cont[5:0]};
          end
          if (!bad && (cp > u8cp_pkg::MaxCodePt ||
                       (cp >= u8cp_pkg::SurrLo && cp <= u8cp_pkg::SurrHi))) bad = 1'b1;
        end
        if (bad || incomplete) begin
          if (strict) begin
            res = '{code_point: '0, rejected: 1'b1, last_result: 1'b1};
            queue_result(res);
            held_cnt = 0;
            skipping = !eos;
            return 1'b1;
          end
          res = '{code_point: u8cp_pkg::Replacement, rejected: 1'b0, last_result: 1'b0};
          queue_result(res);
          cnt++;
          if (incomplete) begin
            pos = n;
            break;
          end
          // only the lead goes, the rest is parsed again
          pos += 1;
        end else begin
          res = '{code_point: cp, rejected: 1'b0, last_result: 1'b0};
          queue_result(res);
          cnt++;
          pos += need + 1;
        end
      end
      if (eos) begin
        if (cnt > 0) begin
          res = expected_cps[expected_cps.size() - 1];
          res.last_result = 1'b1;
          expected_cps[expected_cps.size() - 1] = res;
        end
        held_cnt = 0;
      end else begin
        held_cnt = n - pos;
        for (int i = 0; i < 3; i++) begin
          if (i < held_cnt) held_bytes[i] = seq[pos+i];
        end
      end
      return 1'b1;
    endfunction

    function void compare_field(string name, logic [20:0] exp_v, logic [20:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_codepoint(u8cp_pkg::out_t got);
      u8cp_pkg::out_t exp_r;
      if (expected_cps.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %h", $time, got);
        return;
      end
      exp_r = expected_cps.pop_front();
      compare_field("code_point", exp_r.code_point, got.code_point);
      compare_field("rejected", {20'd0, exp_r.rejected}, {20'd0, got.rejected});
      compare_field("last_result", {20'd0, exp_r.last_result}, {20'd0, got.last_result});
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  u8cp_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_ready_i;
  u8cp_pkg::out_t out_data_o;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic           cfg_data_i;

  codepoint_tracker tracker;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  logic [7:0]       str_bytes[$];

  utf8_to_codepoint_decoder_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: check on every accepted result, then pick the next ready at random
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) tracker.check_codepoint(out_data_o);
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // one byte item; valid is left high after acceptance so back-to-back items need no gap
  task automatic send_byte(logic [7:0] data, logic eos);
    u8cp_pkg::in_t item;
    item.data_byte     = data;
    item.end_of_string = eos;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    void'(tracker.predict_byte(item));
  endtask

  // sends the queued string, end of string on its final byte
  task automatic send_string();
    for (int i = 0; i < str_bytes.size(); i++) begin
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
    end
    str_bytes.delete();
  endtask

  // close the input, let every expected result come out, then allow for the pipeline
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.expected_cps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_mode(bit mode);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tracker.set_mode(mode);
  endtask

  function automatic void append_byte(logic [7:0] b);
    str_bytes = {str_bytes, b};
  endfunction

  // appends cp encoded in len bytes; a len above the minimum makes an overlong form
  function automatic void push_utf8(logic [20:0] cp, int unsigned len);
    case (len)
      1: begin
        append_byte({1'b0, cp[6:0]});
      end
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void push_bytes(logic [7:0] b[]);
    foreach (b[i]) append_byte(b[i]);
  endfunction

  // mostly well-formed strings, some broken, some illegal values, some noise
  task automatic send_random_string();
    int unsigned kind;
    int unsigned chars;
    int unsigned cls;
    logic [20:0] cp;
    kind  = $urandom_range(0, 9);
    chars = $urandom_range(1, 5);
    if (kind == 9) begin
      repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
    end else begin
      for (int c = 0; c < chars; c++) begin
        cls = $urandom_range(0, 3);
        case (cls)
          0: push_utf8(21'($urandom_range(0, 16'h7F)), 1);
          1: push_utf8(21'($urandom_range(16'h80, 16'h7FF)), 2);
          2: begin
            cp = 21'($urandom_range(16'h800, 16'hFFFF));
            if (cp >= u8cp_pkg::SurrLo && cp <= u8cp_pkg::SurrHi) cp -= 21'h800;
            push_utf8(cp, 3);
          end
          default: push_utf8(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
        endcase
      end
      case (kind)
        6: str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        7: if (str_bytes.size() > 1) void'(str_bytes.pop_back());
        8: begin
          // surrogate, value above the top of the range, or an overlong form
          case ($urandom_range(0, 2))
            0: push_utf8(21'($urandom_range(16'hD800, 16'hDFFF)), 3);
            1: push_utf8(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
            default: push_utf8(21'($urandom_range(0, 16'h7F)), $urandom_range(2, 4));
          endcase
        end
        default: ;
      endcase
    end
    send_string();
  endtask

  // random strings until target bytes have been decoded, mode changes now and then
  task automatic run_random(int unsigned target);
    int unsigned start;
    start = tracker.decoded_bytes;
    while (tracker.decoded_bytes - start < target) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_mode($urandom_range(0, 1));
      end
      send_random_string();
    end
  endtask

  initial begin
    tracker       = new();
    send_idle_pct = 10;
    recv_idle_pct = 64;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // lenient mode
    write_mode(1'b0);
    // all lengths, smallest byte, top of the code point range
    push_bytes('{8'h00, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF});
    send_string();
    // above the top of the range: four replacements
    push_bytes('{8'hF4, 8'h90, 8'h80, 8'h80});
    send_string();
    // bad continuation, then a bad lead at the end
    push_bytes('{8'hC3, 8'h41, 8'hFF});
    send_string();
    // overlong form accepted, then cut short by end of string
    push_bytes('{8'hC0, 8'h80, 8'hE2, 8'h82});
    send_string();
    // mode goes strict while a sequence is held
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    drain();
    write_mode(1'b1);
    send_byte(8'h41, 1'b1);
    // strict: surrogate found on the final byte
    push_bytes('{8'hED, 8'hA0, 8'h80});
    send_string();
    // strict: early error, the rest of the string is swallowed
    push_bytes('{8'h80, 8'h41});
    send_string();
    // mode goes lenient while a sequence is held
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    drain();
    write_mode(1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);

    run_random(55);
    drain();
    send_idle_pct = 64;
    recv_idle_pct = 10;
    write_mode(1'b1);
    run_random(55);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mode(1'b0);
    run_random(55);
    drain();
    repeat (16) @(posedge clk_i);

    if (tracker.errors == 0 && tracker.expected_cps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
